// File: rtl/core/keypad_number_entry_defines.svh
// assertion macros shared by the keypad number entry rtl
`ifndef KEYPAD_NUMBER_ENTRY_DEFINES_SVH
`define KEYPAD_NUMBER_ENTRY_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define KNE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled in reset
`define KNE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define KNE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define KNE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/kne_pkg.sv
// shared types, constants and key layout for the keypad number entry block
package kne_pkg;

  localparam logic [3:0] COLS_ALL_HIGH = 4'hF;
  localparam int unsigned KNE_MAX_DIGITS = 9;
  localparam logic [3:0] MAX_DIGITS_RESET = 4'd9;
  localparam logic [3:0] DIGIT_LIMIT_MAX = 4'd9;
  localparam logic [3:0] DIGIT_LIMIT_MIN = 4'd1;
  localparam int unsigned KNE_QDEPTH = 4;
  localparam int unsigned KNE_QPTR_W = $clog2(KNE_QDEPTH);
  localparam int unsigned NUMBER_W = 30;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SCAN = 2'd1,
    PH_WAIT = 2'd2
  } phase_t;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_DIGIT  = 3'd1,
    CMD_ERASE  = 3'd2,
    CMD_EQUALS = 3'd3,
    CMD_CANCEL = 3'd4,
    CMD_ALT    = 3'd5
  } cmd_kind_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_DIGIT  = 3'd1,
    EV_ERASE  = 3'd2,
    EV_DONE   = 3'd3,
    EV_CANCEL = 3'd4,
    EV_ALT    = 3'd5
  } event_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [3:0] digit;
  } key_t;

  // one classified tick passed from the scanner to the number builder
  typedef struct packed {
    logic [3:0] row_drive;
    key_t       key;
  } cmd_t;

  function automatic logic [1:0] lowest_low(input logic [3:0] cols);
    logic [1:0] c;
    c = 2'd0;
    if (!cols[0]) c = 2'd0;
    else if (!cols[1]) c = 2'd1;
    else if (!cols[2]) c = 2'd2;
    else if (!cols[3]) c = 2'd3;
    return c;
  endfunction

  // layout: 7 8 9 /  |  4 5 6 >  |  1 2 3 <  |  - 0 = B
  function automatic key_t key_map(input logic [1:0] row, input logic [1:0] col);
    key_t k;
    k.kind = CMD_NONE;
    k.digit = 4'd0;
    case ({row, col})
      4'h0: begin k.kind = CMD_DIGIT; k.digit = 4'd7; end
      4'h1: begin k.kind = CMD_DIGIT; k.digit = 4'd8; end
      4'h2: begin k.kind = CMD_DIGIT; k.digit = 4'd9; end
      4'h3: k.kind = CMD_CANCEL;
      4'h4: begin k.kind = CMD_DIGIT; k.digit = 4'd4; end
      4'h5: begin k.kind = CMD_DIGIT; k.digit = 4'd5; end
      4'h6: begin k.kind = CMD_DIGIT; k.digit = 4'd6; end
      4'h8: begin k.kind = CMD_DIGIT; k.digit = 4'd1; end
      4'h9: begin k.kind = CMD_DIGIT; k.digit = 4'd2; end
      4'hA: begin k.kind = CMD_DIGIT; k.digit = 4'd3; end
      4'hC: k.kind = CMD_ALT;
      4'hD: begin k.kind = CMD_DIGIT; k.digit = 4'd0; end
      4'hE: k.kind = CMD_EQUALS;
      4'hF: k.kind = CMD_ERASE;
      default: k.kind = CMD_NONE;
    endcase
    return k;
  endfunction

endpackage

// File: rtl/core/kne_queue.sv
// short command queue between the scanner and the number builder
`include "keypad_number_entry_defines.svh"
module kne_queue
  import kne_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_data
);

  cmd_t mem [0:KNE_QDEPTH-1];
  logic [KNE_QPTR_W-1:0] wr_ptr;
  logic [KNE_QPTR_W-1:0] rd_ptr;
  logic [KNE_QPTR_W:0]   fill;
  logic push;
  logic pop;

  assign in_ready  = (fill != (KNE_QPTR_W+1)'(KNE_QDEPTH));
  assign out_valid = (fill != '0);
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;
  assign out_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

  `KNE_ASSERT_IMPL(a_fill_bound, clk, rst, 1'b1, fill <= (KNE_QPTR_W+1)'(KNE_QDEPTH))
  `KNE_ASSERT_NEXT(a_fill_up, clk, rst, push && !pop, fill == $past(fill) + 1'b1)

endmodule

// File: rtl/core/kne_front.sv
// row scanner: takes column beats, drives rows and classifies released keys
`include "keypad_number_entry_defines.svh"
module kne_front
  import kne_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [3:0] col_levels,
  input  logic       q_ready,
  output logic       in_ready,
  output logic       q_valid,
  output cmd_t       cmd
);

  phase_t     phase;
  phase_t     phase_next;
  logic [1:0] scan_row;
  logic [1:0] scan_row_next;
  logic [1:0] held_row;
  logic [1:0] held_row_next;
  logic [1:0] held_col;
  logic [1:0] held_col_next;
  logic       accept;
  logic       any_low;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign accept   = in_valid && q_ready;
  assign any_low  = (col_levels != COLS_ALL_HIGH);

  always_comb begin
    phase_next    = phase;
    scan_row_next = scan_row;
    held_row_next = held_row;
    held_col_next = held_col;
    case (phase)
      PH_SCAN: begin
        if (any_low) begin
          held_row_next = scan_row;
          held_col_next = lowest_low(col_levels);
          phase_next    = PH_WAIT;
        end else if (scan_row == 2'd3) begin
          scan_row_next = 2'd0;
          phase_next    = PH_IDLE;
        end else begin
          scan_row_next = scan_row + 2'd1;
        end
      end
      PH_WAIT: begin
        if (!any_low) phase_next = PH_IDLE;
      end
      default: begin
        phase_next = PH_IDLE;
        if (any_low) begin
          scan_row_next = 2'd0;
          phase_next    = PH_SCAN;
        end
      end
    endcase
  end

  always_comb begin
    cmd.row_drive = 4'd0;
    cmd.key.kind  = CMD_NONE;
    cmd.key.digit = 4'd0;
    case (phase)
      PH_SCAN: cmd.row_drive = ~(4'd1 << scan_row);
      PH_WAIT: begin
        // key acts on release
        if (!any_low) cmd.key = key_map(held_row, held_col);
      end
      default: cmd.row_drive = 4'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      scan_row <= 2'd0;
      held_row <= 2'd0;
      held_col <= 2'd0;
    end else if (accept) begin
      phase    <= phase_next;
      scan_row <= scan_row_next;
      held_row <= held_row_next;
      held_col <= held_col_next;
    end
  end

  `KNE_ASSERT_IMPL(a_scan_one_row, clk, rst, phase == PH_SCAN, $onehot(~cmd.row_drive))

endmodule

// File: rtl/core/kne_back.sv
// number builder: applies key commands and holds the result register
`include "keypad_number_entry_defines.svh"
module kne_back
  import kne_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  input  logic                q_valid,
  output logic                q_ready,
  input  cmd_t                cmd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          row_drive,
  output event_t              event_res,
  output logic [3:0]          digit,
  output logic [NUMBER_W-1:0] number,
  output logic [3:0]          digit_count
);

  logic [3:0]          max_digits;
  logic [3:0]          limit;
  logic [NUMBER_W-1:0] acc;
  logic [NUMBER_W-1:0] acc_next;
  logic [3:0]          count;
  logic [3:0]          count_next;
  // number held before each appended digit, indexed by digit position
  logic [NUMBER_W-1:0] prefix [0:KNE_MAX_DIGITS-1];
  logic                push_prefix;
  logic [NUMBER_W-1:0] acc_ten;
  logic                pop;
  event_t              ev;
  logic [3:0]          dig;
  logic [NUMBER_W-1:0] num_out;
  logic [3:0]          cnt_out;

  assign q_ready = !out_valid || out_ready;
  assign pop     = q_valid && q_ready;
  assign acc_ten = {acc[NUMBER_W-4:0], 3'b000} + {acc[NUMBER_W-2:0], 1'b0};

  always_comb begin
    if (max_digits == 4'd0) limit = DIGIT_LIMIT_MIN;
    else if (max_digits > DIGIT_LIMIT_MAX) limit = DIGIT_LIMIT_MAX;
    else limit = max_digits;
  end

  always_comb begin
    acc_next    = acc;
    count_next  = count;
    push_prefix = 1'b0;
    ev          = EV_NONE;
    dig         = 4'd0;
    case (cmd.key.kind)
      CMD_DIGIT: begin
        if (count < limit) begin
          push_prefix = 1'b1;
          dig         = cmd.key.digit;
          acc_next    = acc_ten + {{(NUMBER_W-4){1'b0}}, cmd.key.digit};
          count_next  = count + 4'd1;
          ev          = EV_DIGIT;
        end
      end
      CMD_ERASE: begin
        if (count != 4'd0) begin
          acc_next   = prefix[count - 4'd1];
          count_next = count - 4'd1;
          ev         = EV_ERASE;
        end
      end
      CMD_EQUALS: begin
        if (count != 4'd0) ev = EV_DONE;
      end
      CMD_CANCEL: ev = EV_CANCEL;
      CMD_ALT:    ev = EV_ALT;
      default:    ev = EV_NONE;
    endcase
    num_out = acc_next;
    cnt_out = count_next;
    if (ev == EV_CANCEL || ev == EV_ALT) begin
      num_out = '0;
      cnt_out = 4'd0;
    end
    if (ev == EV_DONE || ev == EV_CANCEL || ev == EV_ALT) begin
      acc_next   = '0;
      count_next = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push_prefix) begin
      prefix[count] <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_drive   <= cmd.row_drive;
      event_res   <= ev;
      digit       <= dig;
      number      <= num_out;
      digit_count <= cnt_out;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_digits <= MAX_DIGITS_RESET;
      acc        <= '0;
      count      <= 4'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) max_digits <= cfg_wdata;
      if (pop) begin
        acc   <= acc_next;
        count <= count_next;
      end
      if (pop) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  `KNE_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= 4'(KNE_MAX_DIGITS))
  `KNE_ASSERT_NEXT(a_abort_clears, clk, rst, pop && (ev == EV_CANCEL || ev == EV_ALT),
                   acc == '0 && count == 4'd0 && number == '0)

endmodule

// File: rtl/core/keypad_number_entry.sv
// keypad number entry: a column beat is queued, then its result beat is registered in the builder
// throughput one beat per cycle unless the queue is full; a 4-entry command queue absorbs output stalls
// the scanner advances only on accepted beats, the builder only on queue pops
// synchronous reset: scanner idle, number and digit count cleared, queue
// emptied, max_digits back to 9
module keypad_number_entry
  import kne_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // col_levels[3:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // row_drive[3:0] digit[7:4] number[37:8] digit_count[41:38]
  output logic [2:0]  m_tuser    // event_res[2:0]
);

  logic                f_valid;
  logic                f_ready;
  cmd_t                f_cmd;
  logic                b_valid;
  logic                b_ready;
  cmd_t                b_cmd;
  logic [3:0]          row_drive;
  event_t              event_res;
  logic [3:0]          digit;
  logic [NUMBER_W-1:0] number;
  logic [3:0]          digit_count;

  kne_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .col_levels (s_tdata[3:0]),
    .q_ready    (f_ready),
    .in_ready   (s_tready),
    .q_valid    (f_valid),
    .cmd        (f_cmd)
  );

  kne_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_cmd),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_data  (b_cmd)
  );

  kne_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .q_valid     (b_valid),
    .q_ready     (b_ready),
    .cmd         (b_cmd),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .row_drive   (row_drive),
    .event_res   (event_res),
    .digit       (digit),
    .number      (number),
    .digit_count (digit_count)
  );

  assign m_tdata = {6'd0, digit_count, number, digit, row_drive};
  assign m_tuser = event_res;

endmodule

// File: test/tb.sv
// testbench for keypad_number_entry: scripted key presses plus random scans, checked beat by beat
`timescale 1ns / 100ps

module tb;
  import kne_pkg::*;

  typedef struct packed {
    logic [3:0]  row_drive;
    event_t      ev;
    logic [3:0]  digit;
    logic [29:0] number;
    logic [3:0]  digit_count;
  } keypad_res_t;

  typedef struct packed {
    logic [3:0]  cols;
    bit          typed;
    keypad_res_t res;
  } dir_row_t;

  localparam int N_DIR = 27;
  localparam int N_PHASES = 6;
  localparam int PHASE_BEATS = 250;
  localparam int HOLD_CYCLES = 300;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [3:0]  cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // col_levels[3:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;    // row_drive[3:0] digit[7:4] number[37:8] digit_count[41:38]
  logic [2:0]  m_tuser;    // event_res[2:0]

  // predictor state
  phase_t      kp_phase = PH_IDLE;
  logic [1:0]  kp_scan_row = 2'd0;
  logic [1:0]  kp_held_row = 2'd0;
  logic [1:0]  kp_held_col = 2'd0;
  logic [3:0]  kp_count = 4'd0;
  logic [29:0] kp_number = 30'd0;
  logic [3:0]  kp_max = MAX_DIGITS_RESET;
  string       key_layout = "789/456>123<-0=B";

  keypad_res_t pending_results [$];
  dir_row_t    dir_rows [N_DIR];

  logic [3:0] phase_max [N_PHASES] = '{4'd9, 4'd1, 4'd0, 4'd15, 4'd4, 4'd9};
  int phase_send_idle [N_PHASES] = '{0, 57, 0, 38, 0, 57};
  int phase_rcv_stall [N_PHASES] = '{0, 0, 57, 38, 0, 0};

  int send_idle_pct = 0;
  int rcv_stall_pct = 0;
  bit pressure_on = 1'b0;
  int mismatches = 0;
  int beats_sent = 0;
  int results_checked = 0;
  int ev_seen [8];

  keypad_number_entry DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

  // one tick of the scanner and number builder
  function automatic keypad_res_t predict_tick(input logic [3:0] cols);
    keypad_res_t r;
    logic [7:0]  key;
    logic [3:0]  lim;
    logic [1:0]  lo;
    r = '0;
    lim = (kp_max == 4'd0) ? DIGIT_LIMIT_MIN : (kp_max > DIGIT_LIMIT_MAX) ? DIGIT_LIMIT_MAX : kp_max;
    case (kp_phase)
      PH_SCAN: begin
        r.row_drive = ~(4'b0001 << kp_scan_row);
        if (cols != COLS_ALL_HIGH) begin
          lo = 2'd0;
          for (int c = 3; c >= 0; c--) if (!cols[c]) lo = 2'(c);
          kp_held_row = kp_scan_row;
          kp_held_col = lo;
          kp_phase = PH_WAIT;
        end else if (kp_scan_row == 2'd3) begin
          kp_scan_row = 2'd0;
          kp_phase = PH_IDLE;
        end else begin
          kp_scan_row = kp_scan_row + 2'd1;
        end
      end
      PH_WAIT: begin
        if (cols == COLS_ALL_HIGH) begin
          key = key_layout[{kp_held_row, kp_held_col}];
          kp_phase = PH_IDLE;
          if (key >= "0" && key <= "9") begin
            if (kp_count < lim) begin
              r.digit = 4'(key - "0");
              kp_number = kp_number * 30'd10 + 30'(r.digit);
              kp_count = kp_count + 4'd1;
              r.ev = EV_DIGIT;
            end
          end else if (key == "B") begin
            if (kp_count != 4'd0) begin
              kp_number = kp_number / 30'd10;
              kp_count = kp_count - 4'd1;
              r.ev = EV_ERASE;
            end
          end else if (key == "=") begin
            if (kp_count != 4'd0) r.ev = EV_DONE;
          end else if (key == "/") begin
            r.ev = EV_CANCEL;
          end else if (key == "-") begin
            r.ev = EV_ALT;
          end
        end
      end
      default: begin
        kp_phase = PH_IDLE;
        if (cols != COLS_ALL_HIGH) begin
          kp_scan_row = 2'd0;
          kp_phase = PH_SCAN;
        end
      end
    endcase
    r.number = kp_number;
    r.digit_count = kp_count;
    if (r.ev == EV_DONE || r.ev == EV_CANCEL || r.ev == EV_ALT) begin
      kp_number = 30'd0;
      kp_count = 4'd0;
      if (r.ev != EV_DONE) begin
        r.number = 30'd0;
        r.digit_count = 4'd0;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    mismatches++;
    if (mismatches <= 50)
      $display("tb: mismatch on %s: got %0h, expected %0h at %0t", what, got, exp_val, $time);
  endtask

  task automatic send_cols(input logic [3:0] cols, input bit typed, input keypad_res_t typed_res);
    keypad_res_t pred;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {4'h0, cols};
    @(posedge clk);
    while (s_tready !== 1'b1) @(posedge clk);
    pred = predict_tick(cols);
    pending_results.push_back(typed ? typed_res : pred);
    beats_sent++;
  endtask

  // full press of the key at layout position pos; broken presses bounce off before the row hit
  task automatic press_key(input int pos, input bit broken);
    int row;
    int col;
    logic [3:0] cols;
    row = pos / 4;
    col = pos % 4;
    while (kp_phase != PH_IDLE) send_cols(COLS_ALL_HIGH, 1'b0, '0);
    cols = 4'($urandom_range(15));
    cols[col] = 1'b0;
    send_cols(cols, 1'b0, '0);
    for (int r = 0; r < row; r++) send_cols(COLS_ALL_HIGH, 1'b0, '0);
    if (broken) begin
      send_cols(COLS_ALL_HIGH, 1'b0, '0);
      return;
    end
    cols = 4'($urandom_range(15));
    cols[col] = 1'b0;
    for (int c = 0; c < col; c++) cols[c] = 1'b1;
    send_cols(cols, 1'b0, '0);
    repeat ($urandom_range(0, 3)) send_cols(4'($urandom_range(0, 14)), 1'b0, '0);
    send_cols(COLS_ALL_HIGH, 1'b0, '0);
  endtask

  // result side: random stalls, one long hold-off while pressure is on
  initial begin
    int  hold_cnt;
    bit  hold_done;
    keypad_res_t exp_res;
    keypad_res_t got;
    hold_cnt = 0;
    hold_done = 1'b0;
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid === 1'b1 && m_tready) begin
        got.row_drive = m_tdata[3:0];
        got.digit = m_tdata[7:4];
        got.number = m_tdata[37:8];
        got.digit_count = m_tdata[41:38];
        got.ev = event_t'(m_tuser);
        ev_seen[m_tuser]++;
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result beat", m_tdata[31:0], 32'd0);
        end else begin
          exp_res = pending_results.pop_front();
          results_checked++;
          if (got.row_drive !== exp_res.row_drive)
            report_mismatch("row_drive", got.row_drive, exp_res.row_drive);
          if (got.ev !== exp_res.ev)
            report_mismatch("event_res", got.ev, exp_res.ev);
          if (got.digit !== exp_res.digit)
            report_mismatch("digit", got.digit, exp_res.digit);
          if (got.number !== exp_res.number)
            report_mismatch("number", got.number, exp_res.number);
          if (got.digit_count !== exp_res.digit_count)
            report_mismatch("digit_count", got.digit_count, exp_res.digit_count);
        end
      end
      if (pressure_on && !hold_done) begin
        hold_cnt = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_cnt > 0) begin
        m_tready <= 1'b0;
        hold_cnt--;
      end else begin
        m_tready <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  initial begin
    int start_beats;
    int pos;
    int mode;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= 4'd0;
    s_tvalid <= 1'b0;
    s_tdata <= 8'h00;
    // presses: 9, cancel, empty scan, erase with nothing held, all columns low, equals
    dir_rows = '{
      '{4'hB, 1'b1, '{4'h0, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hB, 1'b1, '{4'hE, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'h3, 1'b0, '0},
      '{4'hF, 1'b1, '{4'h0, EV_DIGIT,  4'd9, 30'd9, 4'd1}},
      '{4'h7, 1'b1, '{4'h0, EV_NONE,   4'd0, 30'd9, 4'd1}},
      '{4'h7, 1'b1, '{4'hE, EV_NONE,   4'd0, 30'd9, 4'd1}},
      '{4'hF, 1'b1, '{4'h0, EV_CANCEL, 4'd0, 30'd0, 4'd0}},
      '{4'hE, 1'b1, '{4'h0, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'hE, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'hD, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'hB, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'h7, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'h7, 1'b1, '{4'h0, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'hE, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'hD, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'hB, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'h7, 1'b1, '{4'h7, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'h0, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'h0, 1'b1, '{4'h0, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'h0, 1'b1, '{4'hE, EV_NONE,   4'd0, 30'd0, 4'd0}},
      '{4'hF, 1'b1, '{4'h0, EV_DIGIT,  4'd7, 30'd7, 4'd1}},
      '{4'hB, 1'b0, '0},
      '{4'hF, 1'b0, '0},
      '{4'hF, 1'b0, '0},
      '{4'hF, 1'b0, '0},
      '{4'hB, 1'b0, '0},
      '{4'hF, 1'b1, '{4'h0, EV_DONE,   4'd0, 30'd7, 4'd1}}
    };
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) send_cols(dir_rows[i].cols, dir_rows[i].typed, dir_rows[i].res);

    for (int p = 0; p < N_PHASES; p++) begin
      s_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clk);
      repeat (4) @(posedge clk);
      cfg_we <= 1'b1;
      cfg_wdata <= phase_max[p];
      @(posedge clk);
      cfg_we <= 1'b0;
      kp_max = phase_max[p];
      send_idle_pct = phase_send_idle[p];
      rcv_stall_pct = phase_rcv_stall[p];
      pressure_on = (p == 4);
      start_beats = beats_sent;
      while (beats_sent - start_beats < PHASE_BEATS) begin
        mode = $urandom_range(99);
        if (mode < 80) begin
          // digits weighted up so the limit gets hit
          if ($urandom_range(99) < 65) begin
            do pos = $urandom_range(15);
            while (!(key_layout[pos] >= "0" && key_layout[pos] <= "9"));
          end else begin
            pos = $urandom_range(15);
          end
          press_key(pos, mode < 8);
        end else begin
          repeat ($urandom_range(1, 6)) send_cols(4'($urandom_range(15)), 1'b0, '0);
        end
      end
    end

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("tb: %0d column beats sent, %0d result beats checked, digit limits 9 1 0 15 4 9",
             beats_sent, results_checked);
    $display("tb: events seen: digit %0d, erase %0d, done %0d, cancel %0d, alt exit %0d",
             ev_seen[EV_DIGIT], ev_seen[EV_ERASE], ev_seen[EV_DONE], ev_seen[EV_CANCEL],
             ev_seen[EV_ALT]);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
